// ===== hw/rtl/mlsu_pkg.sv =====
// ----------------------------------------------------------------------------
// mlsu_pkg: shared types and constants
// Payload structs, register indexes and the exponential table of the
// lattice site update.
// ----------------------------------------------------------------------------
package mlsu_pkg;

	localparam int SITES = 32;
	localparam int SITE_W = 5;
	localparam logic [31:0] RESET_SITE = 32'sd6553600;
	localparam logic [17:0] LOG2E_Q16 = 18'd94548;

	localparam logic [1:0] REG_MASS = 2'd0;
	localparam logic [1:0] REG_MOW2 = 2'd1;
	localparam logic [1:0] REG_STEP = 2'd2;

	localparam logic CMD_PROPOSE = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef struct packed {
		logic command;
		logic [4:0] site;
		logic signed [31:0] value;
		logic [15:0] rand_step;
		logic [15:0] rand_accept;
	} in_item_t;

	typedef struct packed {
		logic accepted;
		logic signed [31:0] site_value;
		logic signed [47:0] delta_action;
	} out_item_t;

	function automatic logic [16:0] pow2_tab(input logic [4:0] j);
		case (j)
			5'd0: pow2_tab = 17'd65536;
			5'd1: pow2_tab = 17'd62757;
			5'd2: pow2_tab = 17'd60097;
			5'd3: pow2_tab = 17'd57549;
			5'd4: pow2_tab = 17'd55109;
			5'd5: pow2_tab = 17'd52773;
			5'd6: pow2_tab = 17'd50535;
			5'd7: pow2_tab = 17'd48393;
			5'd8: pow2_tab = 17'd46341;
			5'd9: pow2_tab = 17'd44376;
			5'd10: pow2_tab = 17'd42495;
			5'd11: pow2_tab = 17'd40693;
			5'd12: pow2_tab = 17'd38968;
			5'd13: pow2_tab = 17'd37316;
			5'd14: pow2_tab = 17'd35734;
			5'd15: pow2_tab = 17'd34219;
			default: pow2_tab = 17'd32768;
		endcase
	endfunction

endpackage

// ===== hw/rtl/mlsu_mul.sv =====
// ----------------------------------------------------------------------------
// mlsu_mul: shared multiplier
// Registered signed 34 x 34 product used for the large multiplies of an update.
// ----------------------------------------------------------------------------
module mlsu_mul import mlsu_pkg::*; (
	input logic clk,
	input logic signed [33:0] a,
	input logic signed [33:0] b,
	output logic signed [67:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

// ===== hw/rtl/metropolis_lattice_site_update.sv =====
// ----------------------------------------------------------------------------
// metropolis_lattice_site_update: Metropolis site update
// Periodic lattice of 32 Q16.16 path values with proposal, action change,
// exponential acceptance test and direct site writes.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy low. A write item goes to
// S_END; a propose item steps from S_RDX to S_EXP2, with the large multiplies
// on one registered 34x34 multiplier and the lattice memory read one word per
// cycle. The result appears for one cycle with done high; it cannot be held
// off. Lattice reset is kept by per-site valid bits.
module metropolis_lattice_site_update import mlsu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input in_item_t in_item,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [23:0] cfg_data,
	output logic done,
	output out_item_t result
);
	localparam logic [3:0] S_IDLE = 4'd0, S_RDX = 4'd1, S_RDN = 4'd2, S_RDP = 4'd3,
		S_DISP = 4'd4, S_Y = 4'd5, S_M1 = 4'd6, S_M2 = 4'd7, S_INNER = 4'd8,
		S_HI = 4'd9, S_LO = 4'd10, S_DS = 4'd11, S_EXP = 4'd12, S_EXP2 = 4'd13,
		S_END = 4'd14;

	logic [3:0] state_q;
	logic [23:0] mass_q, mow2_q, step_q;
	logic [31:0] mem [SITES];
	logic [SITES-1:0] vld_q;
	logic [31:0] rd_raw;
	logic [SITE_W-1:0] rd_addr, rd_addr_q;
	in_item_t item_q;
	logic signed [31:0] x_q, y_q;
	logic signed [32:0] n_q;
	logic signed [63:0] inner_q;
	logic signed [63:0] inner_sum;
	logic [62:0] ai_q;
	logic [32:0] ad_q;
	logic [63:0] hi_q;
	logic signed [47:0] ds_q;
	logic signed [33:0] ma, mb;
	logic signed [67:0] mp;
	logic signed [31:0] rd_val;
	logic acc_now;

	mlsu_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	assign busy = (state_q != S_IDLE);
	assign rd_val = vld_q[rd_addr_q] ? $signed(rd_raw) : $signed(RESET_SITE);
	assign inner_sum = inner_q + 64'(mp);

	always_comb begin
		case (state_q)
			S_IDLE: rd_addr = in_item.site;
			S_RDX: rd_addr = item_q.site + 5'd1;
			default: rd_addr = item_q.site - 5'd1;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_raw <= mem[rd_addr];
		rd_addr_q <= rd_addr;
		if (state_q == S_IDLE && start && in_item.command == CMD_WRITE)
			mem[in_item.site] <= in_item.value;
		else if (state_q == S_EXP2 && acc_now)
			mem[item_q.site] <= y_q;
	end

	// operand selection for the shared multiplier
	logic signed [63:0] s_ext;
	always_comb begin
		ma = '0;
		mb = '0;
		s_ext = 64'(y_q) + 64'(x_q);
		case (state_q)
			S_DISP: begin
				ma = 34'($signed({1'b0, step_q}));
				mb = 34'($signed({1'b0, item_q.rand_step, 1'b0})) - 34'sd65536;
			end
			S_M1: begin
				ma = 34'($signed({1'b0, mass_q, 1'b0}));
				mb = 34'(s_ext - 64'(n_q));
			end
			S_M2: begin
				ma = 34'($signed({1'b0, mow2_q}));
				mb = 34'(s_ext);
			end
			S_HI: begin
				ma = $signed({1'b0, ad_q});
				mb = 34'($signed({3'b0, ai_q[62:32]}));
			end
			S_LO: begin
				ma = $signed({1'b0, ad_q});
				mb = $signed({2'b0, ai_q[31:0]});
			end
			S_EXP: begin
				ma = 34'(ds_q[37:0] >> 4);
				mb = 34'($signed({1'b0, LOG2E_Q16}));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	logic signed [63:0] z_full;
	logic [15:0] f;
	logic [16:0] pj, pj1, diff, eb;
	logic [28:0] dm;
	always_comb begin
		// ds*94548 uses ds[37:0] only, split by 16 to keep multiplier width
		z_full = 64'(ds_q[3:0]) * 64'(LOG2E_Q16) + 64'(mp <<< 4);
		z_full = z_full >>> 16;
		f = z_full[15:0];
		pj = pow2_tab({1'b0, f[15:12]});
		pj1 = pow2_tab(5'({1'b0, f[15:12]} + 5'd1));
		diff = pj - pj1;
		dm = 29'(diff) * 29'(f[11:0]);
		eb = pj - 17'(dm >> 12);
		acc_now = (ds_q <= 48'sd0) || (z_full[63:16] < 48'd16 &&
			{1'b0, item_q.rand_accept} < (eb >> z_full[19:16]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mass_q <= 24'd65536;
			mow2_q <= 24'd65536;
			step_q <= 24'd196608;
			vld_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_MASS: mass_q <= cfg_data;
					REG_MOW2: mow2_q <= cfg_data;
					REG_STEP: step_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (start) begin
					if (in_item.command == CMD_WRITE) begin
						vld_q[in_item.site] <= 1'b1;
						state_q <= S_END;
					end else
						state_q <= S_RDX;
				end
				S_EXP2: begin
					if (acc_now) vld_q[item_q.site] <= 1'b1;
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				S_END: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= state_q + 4'd1;
			endcase
		end
	end

	logic signed [32:0] ysum;
	logic signed [32:0] dd;
	assign ysum = 33'(x_q) + 33'($signed(mp[47:16]));
	assign dd = 33'(y_q) - 33'(x_q);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				item_q <= in_item;
				result.accepted <= 1'b1;
				result.site_value <= in_item.value;
				result.delta_action <= '0;
			end
			S_RDX: x_q <= rd_val;
			S_RDN: n_q <= 33'(rd_val);
			S_RDP: n_q <= n_q + 33'(rd_val);
			S_Y: begin
				if (ysum > 33'sd2147483647) y_q <= 32'sh7fffffff;
				else if (ysum < -33'sd2147483648) y_q <= 32'sh80000000;
				else y_q <= ysum[31:0];
			end
			S_M2: inner_q <= 64'(mp);
			S_INNER: begin
				inner_q <= inner_sum;
				ai_q <= inner_sum[63] ? 63'(-inner_sum) : 63'(inner_sum);
				ad_q <= dd[32] ? 33'(-dd) : 33'(dd);
			end
			S_LO: hi_q <= 64'(mp);
			S_DS: begin
				if ((dd[32] != inner_q[63]) && dd != 0 && inner_q != 0)
					ds_q <= -48'((hi_q + 64'(mp[63:32])) >> 17);
				else
					ds_q <= 48'((hi_q + 64'(mp[63:32])) >> 17);
			end
			S_EXP: ;
			S_EXP2: begin
				if (acc_now) begin
					result.accepted <= 1'b1;
					result.site_value <= y_q;
					result.delta_action <= ds_q;
				end else begin
					result.accepted <= 1'b0;
					result.site_value <= x_q;
					result.delta_action <= '0;
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("start not taken");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
endmodule
